// File: design/sha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out;

    // control from the sequencer to the round unit
    typedef struct packed {
        logic       start;
        logic [7:0] pad_byte_unused;
    } t_round_ctl;

    localparam logic [31:0] K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [63:0] BLOCK_BITS = 64'd512;
    localparam logic [5:0]  LEN_OFFSET = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

// File: design/sha_round.sv
`timescale 1ns / 1ps
`default_nettype none
// One SHA-256 round per cycle. For rounds 0..15 each round waits for its
// message word (i_w_valid); the schedule is a 16-word shift window. Hash words
// live in a small memory, read before the rounds and written back after them.
module sha_round (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,     // begin a compression
    input  wire logic        i_w_valid,   // message word for the current round
    input  wire logic [31:0] i_w,
    input  wire logic        i_restart,   // reload initial hash values
    input  wire logic [2:0]  i_rd_addr,
    output logic      [31:0] o_rd_data,
    output logic             o_busy,
    output logic             o_w_ready    // i_w is taken at this edge when valid
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_INIT  = 5'b10000
    } t_state;

    t_state r_state;
    logic [31:0] r_mem [8];
    logic [31:0] r_rd;
    logic [3:0]  r_cnt;
    logic [5:0]  r_rnd;
    logic [31:0] r_v [8];
    logic [31:0] r_win [16];

    logic [2:0]  w_raddr;
    logic [31:0] w_wt, s0, s1, t1, t2;
    logic [31:0] a, e;

    always_comb begin
        w_raddr = i_rd_addr;
        if (r_state == S_LOAD) w_raddr = r_cnt[2:0];
        if (r_state == S_ADD) w_raddr = r_cnt[2:0];
        s0 = sha_pkg::rotr(r_win[1], 7) ^ sha_pkg::rotr(r_win[1], 18) ^ (r_win[1] >> 3);
        s1 = sha_pkg::rotr(r_win[14], 17) ^ sha_pkg::rotr(r_win[14], 19)
             ^ (r_win[14] >> 10);
        w_wt = (r_rnd < 6'd16) ? i_w : (r_win[0] + s0 + r_win[9] + s1);
        a = r_v[0];
        e = r_v[4];
        t1 = r_v[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
             + ((e & r_v[5]) ^ (~e & r_v[6])) + sha_pkg::K[r_rnd] + w_wt;
        t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
             + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[w_raddr];
    end
    assign o_rd_data = r_rd;
    assign o_busy = (r_state != S_IDLE) || i_start;
    assign o_w_ready = (r_state == S_ROUND) && (r_rnd < 6'd16);

    // load is pipelined: address n issued at cnt n, data lands at cnt n+1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_rnd   <= '0;
        end else begin
            case (r_state)
                S_INIT: begin
                    r_mem[r_cnt[2:0]] <= sha_pkg::H_INIT[r_cnt[2:0]];
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd7) begin
                        r_cnt <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_restart) begin
                        r_state <= S_INIT;
                    end else if (i_start) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_cnt != 4'd0) r_v[r_cnt[2:0] - 3'd1] <= r_rd;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd8) begin
                        r_cnt <= '0;
                        r_rnd <= '0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (r_rnd >= 6'd16 || i_w_valid) begin
                        r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                        r_v[4] <= r_v[3] + t1;
                        r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                        r_v[0] <= t1 + t2;
                        for (int j = 0; j < 15; j++) r_win[j] <= r_win[j + 1];
                        r_win[15] <= w_wt;
                        r_rnd <= r_rnd + 6'd1;
                        if (r_rnd == 6'd63) begin
                            r_cnt <= '0;
                            r_state <= S_ADD;
                        end
                    end
                end
                S_ADD: begin
                    if (r_cnt != 4'd0)
                        r_mem[r_cnt[2:0] - 3'd1] <= r_rd + r_v[r_cnt[2:0] - 3'd1];
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd8) begin
                        r_cnt <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_INIT;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: design/sha256_byte_stream_hasher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | payload        | handshake
// in      | in  | sha_pkg::t_in  | i_in_valid / o_in_stall
// out     | out | sha_pkg::t_out | o_out_valid / i_out_stall
// Byte requests are accepted back to back while the input is not stalled. The
// 64th byte, and each padding block at end of message, runs a compression with
// input stalled: start, load, rounds 0..15 (each waits on four byte reads), the
// other 48 rounds and write back. Then four digest words, each read as two
// halves and held while the output stalls. After reset, and after the last
// word, the hash memory reloads with input stalled.
module sha256_byte_stream_hasher_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire sha_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output sha_pkg::t_out      o_out
);
    typedef enum logic [5:0] {
        S_IN    = 6'b000001,
        S_FEED  = 6'b000010,
        S_WAIT  = 6'b000100,
        S_RD    = 6'b001000,
        S_OUT   = 6'b010000,
        S_RST   = 6'b100000
    } t_state;

    t_state r_state;
    logic [7:0]  r_blk [64];
    logic [7:0]  r_bq;
    logic [5:0]  r_fill;
    logic [63:0] r_total, r_bits;
    logic        r_pad, r_final, r_second;
    logic [6:0]  r_n;     // byte position fed into the word builder
    logic [31:0] r_word;
    logic        r_wv;
    logic [3:0]  r_k;
    logic [31:0] r_hi;

    logic        acc, rnd_busy, start, restart;
    logic        w_ready, w_take, feed_adv;
    logic [31:0] rdata;
    logic [2:0]  raddr;
    logic [5:0]  byte_pos;
    logic [7:0]  pbyte;
    logic [2:0]  len_end;

    assign acc = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IN) || rnd_busy;

    // feed moves on unless a built word is still waiting for its round
    assign w_take = r_wv && w_ready;
    assign feed_adv = (r_state == S_FEED) && (!r_wv || w_take);

    always_ff @(posedge i_clk) begin
        if (acc && i_in.byte_valid) r_blk[r_fill] <= i_in.data_byte;
        if (feed_adv) r_bq <= r_blk[r_n[5:0]];
    end

    // padded byte for position r_n-1 (data read into r_bq at the previous feed step)
    always_comb begin
        byte_pos = r_n[5:0] - 6'd1;
        len_end = 3'd7 - byte_pos[2:0];
        pbyte = 8'h00;
        if (!r_pad) pbyte = r_bq;
        else if (!r_second && byte_pos < r_fill) pbyte = r_bq;
        else if (!r_second && byte_pos == r_fill) pbyte = sha_pkg::PAD_BYTE;
        if (r_pad && byte_pos >= sha_pkg::LEN_OFFSET && (r_second || !r_final))
            pbyte = r_bits[len_end * 8 +: 8];
    end

    assign start = (r_state == S_FEED) && (r_n == 7'd1);
    assign restart = (r_state == S_RST);
    assign raddr = r_k[2:0];

    sha_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_w_valid(r_wv),
        .i_w(r_word), .i_restart(restart), .i_rd_addr(raddr),
        .o_rd_data(rdata), .o_busy(rnd_busy), .o_w_ready(w_ready)
    );

    // r_final: another padding block follows this one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_fill <= '0; r_total <= '0; r_pad <= 1'b0;
            r_final <= 1'b0; r_second <= 1'b0;
            r_n <= '0; r_wv <= 1'b0; r_k <= '0;
            o_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IN: begin
                    if (acc) begin
                        r_n <= '0;
                        if (i_in.byte_valid && r_fill == 6'd63) begin
                            r_fill <= '0;
                            r_pad <= 1'b0;
                            r_state <= S_FEED;
                            if (i_in.end_of_message) begin
                                r_bits <= r_total + sha_pkg::BLOCK_BITS;
                                r_final <= 1'b1;
                            end else r_final <= 1'b0;
                            r_total <= r_total + sha_pkg::BLOCK_BITS;
                        end else if (i_in.end_of_message) begin
                            r_pad <= 1'b1;
                            r_second <= 1'b0;
                            r_fill <= r_fill + {5'd0, i_in.byte_valid};
                            r_final <= (r_fill + {5'd0, i_in.byte_valid})
                                       >= sha_pkg::LEN_OFFSET;
                            r_bits <= r_total
                                + {55'd0, r_fill + {5'd0, i_in.byte_valid}, 3'd0};
                            r_state <= S_FEED;
                        end else if (i_in.byte_valid) begin
                            r_fill <= r_fill + 6'd1;
                        end
                    end
                end
                S_FEED: begin
                    // gather four bytes per word; a word waits until its round takes it
                    if (feed_adv) begin
                        if (r_n == 7'd65) begin
                            r_wv <= 1'b0;
                            r_n <= '0;
                            r_state <= S_WAIT;
                        end else begin
                            if (r_n != 7'd0) r_word <= {r_word[23:0], pbyte};
                            r_wv <= (r_n != 7'd0) && (r_n[1:0] == 2'd0);
                            r_n <= r_n + 7'd1;
                        end
                    end
                end
                S_WAIT: begin
                    if (!rnd_busy) begin
                        r_n <= '0;
                        if (!r_pad && !r_final) r_state <= S_IN;
                        else if (!r_pad) begin
                            // message ended on a block boundary: pad byte and length
                            r_pad <= 1'b1; r_second <= 1'b0; r_final <= 1'b0;
                            r_state <= S_FEED;
                        end else if (r_final && !r_second) begin
                            // length-only block follows
                            r_second <= 1'b1;
                            r_state <= S_FEED;
                        end else begin
                            r_k <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (r_k[0] || r_k == 4'd0) r_k <= r_k + 4'd1;
                    if (r_k[0]) r_hi <= rdata;
                    if (r_k[0] == 1'b0 && r_k != 4'd0) begin
                        o_out.digest_word <= {r_hi, rdata};
                        o_out.word_index <= r_k[2:1] - 2'd1;
                        o_out.last_word <= (r_k == 4'd8);
                        o_out_valid <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // r_k held here so the next high word is read while waiting
                    if (!i_out_stall) begin
                        o_out_valid <= 1'b0;
                        if (o_out.last_word) begin
                            r_fill <= '0; r_total <= '0;
                            r_pad <= 1'b0; r_final <= 1'b0; r_second <= 1'b0;
                            r_state <= S_RST;
                        end else begin
                            r_k <= r_k + 4'd1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RST: r_state <= S_IN;
                default: r_state <= S_IN;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: test/sha256_byte_stream_hasher_core_tb.sv
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_core_tb;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    sha_pkg::t_in  in_req = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    sha_pkg::t_out out_word;

    // predictor state
    logic [31:0]   hash_st [8];
    logic [7:0]    blk_buf [64];
    int unsigned   fill_cnt;
    logic [63:0]   bit_total;
    sha_pkg::t_out digest_q [$];

    int  err_cnt = 0;
    bit  idle_en = 1'b1;

    sha256_byte_stream_hasher_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_word)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block(input logic [7:0] b [64]);
        logic [31:0] w [64];
        logic [31:0] a, bb, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = hash_st[0]; bb = hash_st[1]; c = hash_st[2]; d = hash_st[3];
        e = hash_st[4]; f = hash_st[5]; g = hash_st[6]; h = hash_st[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + sha_pkg::K[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & bb) ^ (a & c) ^ (bb & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = bb; bb = a; a = t1 + t2;
        end
        hash_st[0] += a; hash_st[1] += bb; hash_st[2] += c; hash_st[3] += d;
        hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) hash_st[i] = sha_pkg::H_INIT[i];
        fill_cnt = 0;
        bit_total = '0;
    endtask

    task automatic predict_digest(input sha_pkg::t_in r);
        logic [7:0]    pad [64];
        logic [63:0]   len;
        sha_pkg::t_out o;
        if (r.byte_valid) begin
            blk_buf[fill_cnt] = r.data_byte;
            fill_cnt++;
            if (fill_cnt == 64) begin
                compress_block(blk_buf);
                bit_total += 64'd512;
                fill_cnt = 0;
            end
        end
        if (r.end_of_message) begin
            len = bit_total + 64'(fill_cnt * 8);
            for (int i = 0; i < 64; i++) pad[i] = (i < fill_cnt) ? blk_buf[i] : 8'h00;
            pad[fill_cnt] = sha_pkg::PAD_BYTE;
            if (fill_cnt >= 56) begin
                compress_block(pad);
                for (int i = 0; i < 64; i++) pad[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++) pad[63-i] = len[8*i +: 8];
            compress_block(pad);
            for (int k = 0; k < 4; k++) begin
                o.digest_word = {hash_st[2*k], hash_st[2*k+1]};
                o.word_index  = 2'(k);
                o.last_word   = (k == 3);
                digest_q.push_back(o);
            end
            restart_hash();
        end
    endtask

    // one request; valid stays up across back-to-back requests
    task automatic send_req(input logic [7:0] d, input logic bv, input logic eom);
        sha_pkg::t_in r;
        r.data_byte = d; r.byte_valid = bv; r.end_of_message = eom;
        while (idle_en && $urandom_range(99) < 32) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_digest(r);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge clk);
    endtask

    task automatic send_msg(input int len);
        for (int i = 0; i < len; i++)
            send_req(8'($urandom), 1'b1, (i == len - 1));
        if (len == 0) send_req(8'($urandom), 1'b0, 1'b1);
    endtask

    always @(posedge clk) begin
        if (rst_n) out_stall <= idle_en && ($urandom_range(99) < 32);
        if (rst_n && out_valid && !out_stall) begin
            if (digest_q.size() == 0) begin
                $error("digest word with nothing expected: %h", out_word.digest_word);
                err_cnt++;
            end else begin
                sha_pkg::t_out x;
                x = digest_q.pop_front();
                if (x.digest_word !== out_word.digest_word) begin
                    $error("digest_word exp %h got %h", x.digest_word, out_word.digest_word);
                    err_cnt++;
                end
                if (x.word_index !== out_word.word_index) begin
                    $error("word_index exp %0d got %0d", x.word_index, out_word.word_index);
                    err_cnt++;
                end
                if (x.last_word !== out_word.last_word) begin
                    $error("last_word exp %0d got %0d", x.last_word, out_word.last_word);
                    err_cnt++;
                end
            end
        end
    end

    task automatic test_empty_and_null();
        send_req(8'hff, 1'b0, 1'b0);          // nothing at all
        send_req(8'h00, 1'b0, 1'b1);          // empty message
        send_req(8'hff, 1'b1, 1'b1);          // one byte with end mark
        wait_drained();
    endtask

    task automatic test_pad_boundaries();
        // 56 bytes push the length into a second padding block
        send_msg(56);
        wait_drained();
    endtask

    task automatic test_random_messages();
        int n;
        for (int m = 0; m < 4; m++) begin
            n = int'($urandom_range(5));
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(9) == 0) send_req(8'($urandom), 1'b0, 1'b0);
                send_req(8'($urandom), 1'b1, 1'b0);
            end
            send_req(8'($urandom), 1'($urandom_range(1)), 1'b1);
        end
        wait_drained();
    endtask

    task automatic test_no_idle();
        // end mark on the 64th byte: full block, then pad and length alone
        idle_en = 1'b0;
        send_msg(64);
        wait_drained();
        idle_en = 1'b1;
    endtask

    initial begin
        restart_hash();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_null();
        test_pad_boundaries();
        test_random_messages();
        test_no_idle();
        repeat (200) @(posedge clk);
        if (err_cnt == 0 && digest_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: sha256_byte_stream_hasher_core.f
design/sha_pkg.sv
design/sha_round.sv
design/sha256_byte_stream_hasher_core.sv
test/sha256_byte_stream_hasher_core_tb.sv
